// ===== hw/rtl/mstt_pkg.sv =====
package mstt_pkg;

    // Default table size and the cap on fired results per service transaction
    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

    // Input operation codes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_START_PER = 3'd1;
    localparam logic [2:0] OP_START_ONE = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_SERVICE   = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_FIRED = 2'd2;

    // Result status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // Microprogram step addresses
    typedef enum logic [3:0] {
        U_IDLE,
        U_TRD,
        U_TEV,
        U_SRD,
        U_SEV,
        U_ACK,
        U_CRD,
        U_CEV,
        U_VRD,
        U_VEV,
        U_STASH,
        U_VNX,
        U_FLUSH
    } t_upc;

    // Wait qualifiers: hold the step until the output side can take a transaction
    typedef enum logic [1:0] {
        W_NONE,
        W_OUT,
        W_HELD
    } t_wait;

    // Datapath actions
    typedef enum logic [3:0] {
        A_NONE,
        A_LOAD,
        A_TICK,
        A_ALLOC,
        A_CHK,
        A_CLEAR,
        A_SERV,
        A_STASH,
        A_INC,
        A_ACK,
        A_FLUSH
    } t_act;

    // Branch conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_LAST,
        C_FOUND,
        C_OOR,
        C_REPORT,
        C_FULL
    } t_cond;

    // One control word of the microprogram
    typedef struct packed {
        logic  in_rdy;
        logic  rd;
        t_wait wt;
        t_act  act;
        t_cond cond;
        t_upc  jt;
        t_upc  jf;
    } t_cw;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic last;
        logic found;
        logic oor;
        logic report;
        logic full;
        logic out_free;
        logic held_vld;
    } t_stat;

    // One slot of the timer table
    typedef struct packed {
        logic [31:0] reload;
        logic [31:0] remain;
        logic [7:0]  pend;
        logic [7:0]  hnd;
        logic [15:0] arg;
    } t_slot;

    // Microprogram ROM
    function automatic t_cw ucode(input t_upc pc);
        t_cw cw;
        begin
            cw = '{in_rdy: 1'b0, rd: 1'b0, wt: W_NONE, act: A_NONE,
                   cond: C_ALWAYS, jt: U_IDLE, jf: U_IDLE};
            case (pc)
                U_IDLE: begin
                    cw.in_rdy = 1'b1;
                    cw.act    = A_LOAD;
                    cw.cond   = C_DISPATCH;
                    cw.jf     = U_IDLE;
                end
                U_TRD: begin
                    cw.rd = 1'b1;
                    cw.jt = U_TEV;
                end
                U_TEV: begin
                    cw.act  = A_TICK;
                    cw.cond = C_LAST;
                    cw.jt   = U_IDLE;
                    cw.jf   = U_TRD;
                end
                U_SRD: begin
                    cw.rd = 1'b1;
                    cw.jt = U_SEV;
                end
                U_SEV: begin
                    cw.act  = A_ALLOC;
                    cw.cond = C_FOUND;
                    cw.jt   = U_ACK;
                    cw.jf   = U_SRD;
                end
                U_ACK: begin
                    cw.wt  = W_OUT;
                    cw.act = A_ACK;
                    cw.jt  = U_IDLE;
                end
                U_CRD: begin
                    cw.rd   = 1'b1;
                    cw.act  = A_CHK;
                    cw.cond = C_OOR;
                    cw.jt   = U_ACK;
                    cw.jf   = U_CEV;
                end
                U_CEV: begin
                    cw.act = A_CLEAR;
                    cw.jt  = U_ACK;
                end
                U_VRD: begin
                    cw.rd = 1'b1;
                    cw.jt = U_VEV;
                end
                U_VEV: begin
                    cw.act  = A_SERV;
                    cw.cond = C_REPORT;
                    cw.jt   = U_STASH;
                    cw.jf   = U_VNX;
                end
                U_STASH: begin
                    cw.wt   = W_HELD;
                    cw.act  = A_STASH;
                    cw.cond = C_FULL;
                    cw.jt   = U_FLUSH;
                    cw.jf   = U_VNX;
                end
                U_VNX: begin
                    cw.act  = A_INC;
                    cw.cond = C_LAST;
                    cw.jt   = U_FLUSH;
                    cw.jf   = U_VRD;
                end
                U_FLUSH: begin
                    cw.wt  = W_HELD;
                    cw.act = A_FLUSH;
                    cw.jt  = U_IDLE;
                end
                default: begin
                    cw.jt = U_IDLE;
                end
            endcase
            return cw;
        end
    endfunction

    // Entry step of the routine for each operation; unknown codes stay idle
    function automatic t_upc op_entry(input logic [2:0] op);
        t_upc pc;
        begin
            case (op)
                OP_TICK:      pc = U_TRD;
                OP_START_PER: pc = U_SRD;
                OP_START_ONE: pc = U_SRD;
                OP_CLEAR:     pc = U_CRD;
                OP_SERVICE:   pc = U_VRD;
                default:      pc = U_IDLE;
            endcase
            return pc;
        end
    endfunction

endpackage

// ===== hw/rtl/mstt_seq.sv =====
module mstt_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic [2:0]        i_op,
    input  mstt_pkg::t_stat   i_stat,
    output logic              o_s_tready,
    output mstt_pkg::t_cw     o_cw
);

    mstt_pkg::t_upc r_upc;
    mstt_pkg::t_upc n_upc;
    mstt_pkg::t_cw  rom_cw;
    logic           stall;

    // Fetch the control word of the current step
    assign rom_cw = mstt_pkg::ucode(r_upc);

    // Hold the step while the output side cannot take a transaction
    always_comb begin
        stall = 1'b0;
        case (rom_cw.wt)
            mstt_pkg::W_OUT:  stall = !i_stat.out_free;
            mstt_pkg::W_HELD: stall = i_stat.held_vld && !i_stat.out_free;
            default:          stall = 1'b0;
        endcase
    end

    // Next step: conditional jump between the two targets of the word
    always_comb begin
        n_upc = r_upc;
        if (!stall) begin
            case (rom_cw.cond)
                mstt_pkg::C_ALWAYS:   n_upc = rom_cw.jt;
                mstt_pkg::C_DISPATCH: n_upc = i_s_tvalid ? mstt_pkg::op_entry(i_op)
                                                         : rom_cw.jf;
                mstt_pkg::C_LAST:     n_upc = i_stat.last   ? rom_cw.jt : rom_cw.jf;
                mstt_pkg::C_FOUND:    n_upc = i_stat.found  ? rom_cw.jt : rom_cw.jf;
                mstt_pkg::C_OOR:      n_upc = i_stat.oor    ? rom_cw.jt : rom_cw.jf;
                mstt_pkg::C_REPORT:   n_upc = i_stat.report ? rom_cw.jt : rom_cw.jf;
                mstt_pkg::C_FULL:     n_upc = i_stat.full   ? rom_cw.jt : rom_cw.jf;
                default:              n_upc = mstt_pkg::U_IDLE;
            endcase
        end
    end

    // Drop the action of a stalled step or of an idle step with no transaction
    always_comb begin
        o_cw       = rom_cw;
        o_s_tready = rom_cw.in_rdy;
        if (stall) begin
            o_cw.act = mstt_pkg::A_NONE;
        end
        if (rom_cw.act == mstt_pkg::A_LOAD && !i_s_tvalid) begin
            o_cw.act = mstt_pkg::A_NONE;
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= mstt_pkg::U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== hw/rtl/mstt_dp.sv =====
module mstt_dp #(
    parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mstt_pkg::t_cw     i_cw,
    input  logic [63:0]       i_s_tdata,
    input  logic [2:0]        i_s_tuser,
    input  logic              i_m_tready,
    output mstt_pkg::t_stat   o_stat,
    output logic              o_m_tvalid,
    output logic [31:0]       o_m_tdata,
    output logic [2:0]        o_m_tuser,
    output logic              o_m_tlast
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Latched transaction
    logic [2:0]  r_op;
    logic [31:0] r_period;
    logic [7:0]  r_hnd;
    logic [15:0] r_arg;
    logic        r_oor;

    // Walk state
    logic [IW-1:0]              r_idx;
    logic [IW-1:0]              n_idx;
    logic [mstt_pkg::CNT_W-1:0] r_cnt;
    logic [mstt_pkg::CNT_W-1:0] n_cnt;

    // Slot table with a valid bit per entry; an entry never written reads as zero
    mstt_pkg::t_slot       mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;
    mstt_pkg::t_slot       r_rd_data;
    logic                  r_rd_vld;
    mstt_pkg::t_slot       ent;
    mstt_pkg::t_slot       wr_data;
    logic                  wr_en;

    // Acknowledge and held fired result
    logic [1:0]  r_ack_kind;
    logic        r_ack_status;
    logic [3:0]  r_ack_slot;
    logic [3:0]  r_held_slot;
    logic [7:0]  r_held_hnd;
    logic [15:0] r_held_arg;
    logic        r_held_vld;
    logic        n_held_vld;

    // Output register
    logic        r_m_valid;
    logic        n_m_valid;
    logic [1:0]  r_m_kind;
    logic        r_m_status;
    logic [3:0]  r_m_slot;
    logic [7:0]  r_m_hnd;
    logic [15:0] r_m_arg;
    logic        r_m_last;

    logic        ent_idle;
    logic        idx_last;
    logic        in_oor;
    logic [31:0] rem_dec;
    logic        out_free;
    logic        push_ack;
    logic        push_held;

    // Slot flags
    assign ent      = r_rd_vld ? r_rd_data : '0;
    assign ent_idle = (ent.reload == 32'd0) && (ent.remain == 32'd0);
    assign idx_last = (r_idx == IW'(SLOT_COUNT - 1));
    assign in_oor   = ({1'b0, i_s_tdata[7:0]} >= 9'(SLOT_COUNT));
    assign rem_dec  = (ent.remain != 32'd0) ? (ent.remain - 32'd1) : 32'd0;
    assign out_free = !r_m_valid || i_m_tready;

    assign push_ack  = (i_cw.act == mstt_pkg::A_ACK);
    assign push_held = ((i_cw.act == mstt_pkg::A_STASH) || (i_cw.act == mstt_pkg::A_FLUSH))
                       && r_held_vld;

    // Status to the sequencer
    always_comb begin
        o_stat.last     = idx_last;
        o_stat.found    = ent_idle || idx_last;
        o_stat.oor      = r_oor;
        o_stat.report   = (ent.pend != 8'd0) && (ent.hnd != 8'd0);
        o_stat.full     = (r_cnt == mstt_pkg::CNT_W'(mstt_pkg::MAX_RESULTS - 1));
        o_stat.out_free = out_free;
        o_stat.held_vld = r_held_vld;
    end

    // Write-back value for the current slot
    always_comb begin
        wr_en   = 1'b0;
        wr_data = ent;
        case (i_cw.act)
            mstt_pkg::A_TICK: begin
                wr_en = !ent_idle;
                if (rem_dec == 32'd0) begin
                    wr_data.remain = ent.reload;
                    if (ent.pend != 8'hFF) begin
                        wr_data.pend = ent.pend + 8'd1;
                    end
                end else begin
                    wr_data.remain = rem_dec;
                end
            end
            mstt_pkg::A_ALLOC: begin
                wr_en          = ent_idle;
                wr_data.reload = (r_op == mstt_pkg::OP_START_PER) ? r_period : 32'd0;
                wr_data.remain = r_period;
                wr_data.hnd    = r_hnd;
                wr_data.arg    = r_arg;
            end
            mstt_pkg::A_CLEAR: begin
                wr_en          = 1'b1;
                wr_data.reload = 32'd0;
                wr_data.remain = 32'd0;
                wr_data.hnd    = 8'd0;
                wr_data.arg    = 16'd0;
            end
            mstt_pkg::A_SERV: begin
                wr_en        = (ent.pend != 8'd0);
                wr_data.pend = ent.pend - 8'd1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Advance the slot index and result count
    always_comb begin
        n_idx = r_idx;
        n_cnt = r_cnt;
        case (i_cw.act)
            mstt_pkg::A_LOAD: begin
                n_cnt = '0;
                if (i_s_tuser == mstt_pkg::OP_CLEAR && !in_oor) begin
                    n_idx = i_s_tdata[IW-1:0];
                end else begin
                    n_idx = '0;
                end
            end
            mstt_pkg::A_TICK, mstt_pkg::A_INC: begin
                if (!idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            mstt_pkg::A_ALLOC: begin
                if (!ent_idle && !idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            mstt_pkg::A_STASH: begin
                n_cnt = r_cnt + 1'b1;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // Held result and output register occupancy
    always_comb begin
        n_held_vld = r_held_vld;
        case (i_cw.act)
            mstt_pkg::A_LOAD:  n_held_vld = 1'b0;
            mstt_pkg::A_STASH: n_held_vld = 1'b1;
            mstt_pkg::A_FLUSH: n_held_vld = 1'b0;
            default:           n_held_vld = r_held_vld;
        endcase
        if (push_ack || push_held) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_cnt      <= '0;
            r_held_vld <= 1'b0;
            r_m_valid  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_vld      <= '0;
        end else begin
            r_idx      <= n_idx;
            r_cnt      <= n_cnt;
            r_held_vld <= n_held_vld;
            r_m_valid  <= n_m_valid;
            if (i_cw.rd) begin
                r_rd_vld <= r_vld[r_idx];
            end
            if (wr_en) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_idx] <= wr_data;
        end
        if (i_cw.rd) begin
            r_rd_data <= mem[r_idx];
        end
    end

    // Latch the transaction fields, the acknowledge and the held result
    always_ff @(posedge i_clk) begin
        if (i_cw.act == mstt_pkg::A_LOAD) begin
            r_op     <= i_s_tuser;
            r_period <= i_s_tdata[39:8];
            r_hnd    <= i_s_tdata[47:40];
            r_arg    <= i_s_tdata[63:48];
            r_oor    <= in_oor;
        end
        if (i_cw.act == mstt_pkg::A_ALLOC) begin
            r_ack_kind   <= mstt_pkg::KIND_START;
            r_ack_status <= ent_idle ? mstt_pkg::ST_OK : mstt_pkg::ST_FAIL;
            r_ack_slot   <= ent_idle ? 4'(r_idx) : 4'd0;
        end
        if (i_cw.act == mstt_pkg::A_CHK) begin
            r_ack_kind   <= mstt_pkg::KIND_CLEAR;
            r_ack_status <= r_oor ? mstt_pkg::ST_FAIL : mstt_pkg::ST_OK;
            r_ack_slot   <= r_oor ? 4'd0 : 4'(r_idx);
        end
        if (i_cw.act == mstt_pkg::A_STASH) begin
            r_held_slot <= 4'(r_idx);
            r_held_hnd  <= ent.hnd;
            r_held_arg  <= ent.arg;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (push_ack) begin
            r_m_kind   <= r_ack_kind;
            r_m_status <= r_ack_status;
            r_m_slot   <= r_ack_slot;
            r_m_hnd    <= 8'd0;
            r_m_arg    <= 16'd0;
            r_m_last   <= 1'b1;
        end else if (push_held) begin
            r_m_kind   <= mstt_pkg::KIND_FIRED;
            r_m_status <= mstt_pkg::ST_OK;
            r_m_slot   <= r_held_slot;
            r_m_hnd    <= r_held_hnd;
            r_m_arg    <= r_held_arg;
            r_m_last   <= (i_cw.act == mstt_pkg::A_FLUSH);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'd0, r_m_arg, r_m_hnd, r_m_slot};
    assign o_m_tuser  = {r_m_status, r_m_kind};
    assign o_m_tlast  = r_m_last;

endmodule

// ===== hw/rtl/multi_slot_tick_timer_table_top.sv =====
// Table of software-style timer slots driven by a small microprogram.
// Slave channel: one transaction per command. tuser carries the operation
// (tick, start periodic, start one-shot, clear, service); tdata carries slot,
// period, handler id and handler argument.
// Master channel: acknowledges for start and clear (one transaction each, tlast
// high) and one transaction per fired slot on service, tlast on the final one.
// A tick or an ignored operation gives no transaction.
// Steps, on the single table port: a tick reads and updates each slot in turn;
// a start reads and checks slots until a free one or the last, then acknowledges;
// a clear reads the named slot, clears it unless the id is out of range, and
// acknowledges; a service reads, updates and advances past each slot, with a further
// step per reported slot. A master holding tready low stalls the hand-over steps.
// One command is worked on at a time; tready rises again when the routine
// for the previous command has handed its last result to the output register.
// A stalled receiver holds the output register; the walk waits only when it has
// a further result to hand over. Reset empties every slot (all fields zero),
// drops any pending output and returns the sequencer to its idle step.
module multi_slot_tick_timer_table_top #(
    parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // slot[7:0], period[39:8], handler_id[47:40],
                                     // handler_arg[63:48]
    input  logic [2:0]  i_s_tuser,   // op[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // slot_out[3:0], fired_handler[11:4],
                                     // fired_arg[27:12], zero[31:28]
    output logic [2:0]  o_m_tuser,   // kind[1:0], status[2]
    output logic        o_m_tlast    // last
);

    mstt_pkg::t_cw   cw;
    mstt_pkg::t_stat stat;

    // Step counter and control store
    mstt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cw       (cw)
    );

    // Slot table, arithmetic and output register
    mstt_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cw       (cw),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== bench/multi_slot_tick_timer_table_top_tb.sv =====
module multi_slot_tick_timer_table_top_tb;

    localparam int CLK_PERIOD     = 12;
    localparam int NSLOT          = mstt_pkg::SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS   = 40;
    localparam int SETTLE_CYCLES  = 3 * NSLOT + 8;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int SAT_TICKS      = 258;
    localparam int TIMEOUT_CYCLES = 600000;

    // Operation codes the block ignores
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam int         OP_RESERVED_SPAN  = 3;

    // Receiver behaviour between hold-offs
    typedef enum int {
        RX_ALWAYS,
        RX_SPARSE,
        RX_PATTERN,
        RX_HEAVY
    } t_rx_mode;

    // One result transaction as the block should emit it
    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [3:0]  slot_idx;
        logic [7:0]  hnd;
        logic [15:0] arg;
        logic        last;
    } t_timer_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // slot[7:0], period[39:8], handler_id[47:40],
                              // handler_arg[63:48]
    logic [2:0]  i_s_tuser;   // op[2:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // slot_out[3:0], fired_handler[11:4],
                              // fired_arg[27:12], zero[31:28]
    logic [2:0]  o_m_tuser;   // kind[1:0], status[2]
    logic        o_m_tlast;

    // Shadow copy of the timer table and the results it still owes
    mstt_pkg::t_slot shadow_table [NSLOT];
    t_timer_result   awaited_results [$];

    // Sender and receiver shaping
    int       burst_left;
    logic     gaps_on;
    t_rx_mode rx_mode;
    logic [7:0] rx_pattern;
    int       rx_phase;
    int       hold_req;
    int       hold_left;

    // Run statistics
    int mismatch_count;
    int commands_sent;
    int results_seen;
    int fired_seen;
    int hold_offs;

    t_timer_result head;

    multi_slot_tick_timer_table_top #(
        .SLOT_COUNT(NSLOT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Apply one accepted command to the shadow table and queue its results
    task automatic timer_table_apply(input logic [2:0] op, input logic [7:0] slot,
                                     input logic [31:0] period, input logic [7:0] hnd,
                                     input logic [15:0] arg);
        int            free_idx;
        int            final_idx;
        int            n;
        t_timer_result r;
        begin
            r = '0;
            r.last = 1'b1;
            case (op)
                mstt_pkg::OP_TICK: begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (shadow_table[i].reload != 0 || shadow_table[i].remain != 0) begin
                            if (shadow_table[i].remain != 0)
                                shadow_table[i].remain = shadow_table[i].remain - 1;
                            if (shadow_table[i].remain == 0) begin
                                if (shadow_table[i].pend != 8'hFF)
                                    shadow_table[i].pend = shadow_table[i].pend + 1;
                                shadow_table[i].remain = shadow_table[i].reload;
                            end
                        end
                    end
                end
                mstt_pkg::OP_START_PER, mstt_pkg::OP_START_ONE: begin
                    free_idx = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (free_idx < 0 && shadow_table[i].reload == 0 &&
                            shadow_table[i].remain == 0)
                            free_idx = i;
                    r.kind = mstt_pkg::KIND_START;
                    if (free_idx < 0) begin
                        r.status = mstt_pkg::ST_FAIL;
                    end else begin
                        shadow_table[free_idx].hnd    = hnd;
                        shadow_table[free_idx].arg    = arg;
                        shadow_table[free_idx].reload =
                            (op == mstt_pkg::OP_START_PER) ? period : '0;
                        shadow_table[free_idx].remain = period;
                        r.status   = mstt_pkg::ST_OK;
                        r.slot_idx = 4'(free_idx);
                    end
                    awaited_results.push_back(r);
                end
                mstt_pkg::OP_CLEAR: begin
                    r.kind = mstt_pkg::KIND_CLEAR;
                    if (slot >= NSLOT) begin
                        r.status = mstt_pkg::ST_FAIL;
                    end else begin
                        // pending fires survive a clear
                        shadow_table[slot].reload = '0;
                        shadow_table[slot].remain = '0;
                        shadow_table[slot].hnd    = '0;
                        shadow_table[slot].arg    = '0;
                        r.status   = mstt_pkg::ST_OK;
                        r.slot_idx = slot[3:0];
                    end
                    awaited_results.push_back(r);
                end
                mstt_pkg::OP_SERVICE: begin
                    // find the final reporting slot first so tlast can be placed
                    n = 0;
                    final_idx = -1;
                    for (int i = 0; i < NSLOT && n < mstt_pkg::MAX_RESULTS; i++)
                        if (shadow_table[i].pend != 0 && shadow_table[i].hnd != 0) begin
                            final_idx = i;
                            n++;
                        end
                    n = 0;
                    for (int i = 0; i < NSLOT && n < mstt_pkg::MAX_RESULTS; i++)
                        if (shadow_table[i].pend != 0) begin
                            shadow_table[i].pend = shadow_table[i].pend - 1;
                            if (shadow_table[i].hnd != 0) begin
                                r.kind     = mstt_pkg::KIND_FIRED;
                                r.status   = mstt_pkg::ST_OK;
                                r.slot_idx = 4'(i);
                                r.hnd      = shadow_table[i].hnd;
                                r.arg      = shadow_table[i].arg;
                                r.last     = (i == final_idx);
                                awaited_results.push_back(r);
                                n++;
                            end
                        end
                end
                default: begin
                end
            endcase
        end
    endtask

    // Offer one command, honouring the burst and gap pattern, and predict on acceptance
    task automatic send_command(input logic [2:0] op, input logic [7:0] slot,
                                input logic [31:0] period, input logic [7:0] hnd,
                                input logic [15:0] arg);
        begin
            @(negedge i_clk);
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                if (gaps_on) begin
                    i_s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end
            end
            burst_left--;
            i_s_tvalid <= 1'b1;
            i_s_tuser  <= op;
            i_s_tdata  <= {arg, hnd, period, slot};
            do @(posedge i_clk); while (!o_s_tready);
            timer_table_apply(op, slot, period, hnd, arg);
            commands_sent++;
        end
    endtask

    // Stop offering and wait until every owed result has arrived
    task automatic wait_drained(input int settle);
        begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            while (awaited_results.size() != 0) @(posedge i_clk);
            repeat (settle) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        begin
            if (want !== got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
                mismatch_count++;
            end
        end
    endtask

    // Drive tready: long hold-offs first, otherwise the current stall pattern
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            rx_phase++;
            case (rx_mode)
                RX_ALWAYS:  i_m_tready <= 1'b1;
                RX_SPARSE:  i_m_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: i_m_tready <= rx_pattern[rx_phase % 8];
                default:    i_m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // Compare each result transaction with the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser 0x%0h",
                         $time, o_m_tdata, o_m_tuser);
                mismatch_count++;
            end else begin
                head = awaited_results.pop_front();
                if (head.kind == mstt_pkg::KIND_FIRED)
                    fired_seen++;
                check_field("kind", 32'(head.kind), 32'(o_m_tuser[1:0]));
                check_field("status", 32'(head.status), 32'(o_m_tuser[2]));
                check_field("slot_out", 32'(head.slot_idx), 32'(o_m_tdata[3:0]));
                check_field("fired_handler", 32'(head.hnd), 32'(o_m_tdata[11:4]));
                check_field("fired_arg", 32'(head.arg), 32'(o_m_tdata[27:12]));
                check_field("tdata padding", 32'd0, 32'(o_m_tdata[31:28]));
                check_field("last", 32'(head.last), 32'(o_m_tlast));
            end
        end
    end

    // Empty table: service and tick with nothing active, clear edges, ignored codes
    task automatic test_empty_table;
        begin
            rx_mode = RX_ALWAYS;
            gaps_on = 1'b0;
            send_command(mstt_pkg::OP_SERVICE, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
            send_command(mstt_pkg::OP_TICK, 8'h00, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_CLEAR, 8'd0, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_CLEAR, 8'(NSLOT - 1), 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_CLEAR, 8'(NSLOT), 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
            for (int k = 0; k < OP_RESERVED_SPAN; k++)
                send_command(3'(OP_RESERVED_FIRST + k), 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                             16'hFFFF);
        end
    endtask

    // Starts of both kinds, zero period, extreme fields, firing and silent handler
    task automatic test_start_and_fire;
        begin
            rx_mode = RX_SPARSE;
            gaps_on = 1'b1;
            send_command(mstt_pkg::OP_START_PER, 8'h00, 32'd1, 8'hFF, 16'hFFFF);
            send_command(mstt_pkg::OP_START_ONE, 8'h00, 32'd2, 8'h01, 16'h0000);
            send_command(mstt_pkg::OP_START_PER, 8'h00, 32'd0, 8'h05, 16'h1234);
            send_command(mstt_pkg::OP_START_ONE, 8'hFF, 32'hFFFF_FFFF, 8'h80, 16'h8000);
            send_command(mstt_pkg::OP_START_PER, 8'h00, 32'd1, 8'h00, 16'h5A5A);
            send_command(mstt_pkg::OP_TICK, 8'h00, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_TICK, 8'h00, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_SERVICE, 8'h00, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_SERVICE, 8'h00, 32'h0, 8'h00, 16'h0000);
        end
    endtask

    // A clear drops the handler but keeps pending fires for the next owner
    task automatic test_clear_keeps_pending;
        begin
            rx_mode    = RX_PATTERN;
            rx_pattern = 8'b1011_0110;
            send_command(mstt_pkg::OP_TICK, 8'h00, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_CLEAR, 8'd0, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_SERVICE, 8'h00, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_START_ONE, 8'h00, 32'd3, 8'h42, 16'hBEEF);
            send_command(mstt_pkg::OP_SERVICE, 8'h00, 32'h0, 8'h00, 16'h0000);
        end
    endtask

    // Fill the table, then hold the receiver off so the block backs up its input
    task automatic test_backpressure;
        begin
            rx_mode = RX_ALWAYS;
            gaps_on = 1'b0;
            for (int i = 0; i < NSLOT; i++)
                send_command(mstt_pkg::OP_CLEAR, 8'(i), 32'h0, 8'h00, 16'h0000);
            for (int i = 0; i <= NSLOT; i++)
                send_command(mstt_pkg::OP_START_PER, 8'($urandom), 32'd1,
                             8'($urandom_range(1, 255)), 16'($urandom));
            send_command(mstt_pkg::OP_TICK, 8'h00, 32'h0, 8'h00, 16'h0000);
            hold_req = HOLD_OFF_LEN;
            hold_offs++;
            send_command(mstt_pkg::OP_SERVICE, 8'h00, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_START_ONE, 8'h00, 32'd7, 8'h11, 16'h2222);
            send_command(mstt_pkg::OP_CLEAR, 8'd3, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_START_ONE, 8'h00, 32'd2, 8'h33, 16'h4444);
            send_command(mstt_pkg::OP_TICK, 8'h00, 32'h0, 8'h00, 16'h0000);
            send_command(mstt_pkg::OP_SERVICE, 8'h00, 32'h0, 8'h00, 16'h0000);
            wait_drained(SETTLE_CYCLES);
        end
    endtask

    // Drive pending counts into saturation, then drain a few services
    task automatic test_pending_saturation;
        begin
            rx_mode = RX_SPARSE;
            gaps_on = 1'b1;
            for (int k = 0; k < SAT_TICKS; k++)
                send_command(mstt_pkg::OP_TICK, 8'($urandom), 32'($urandom),
                             8'($urandom), 16'($urandom));
            for (int k = 0; k < 3; k++)
                send_command(mstt_pkg::OP_SERVICE, 8'h00, 32'h0, 8'h00, 16'h0000);
            for (int i = 0; i < NSLOT; i++)
                send_command(mstt_pkg::OP_CLEAR, 8'(i), 32'h0, 8'h00, 16'h0000);
        end
    endtask

    // Weighted random traffic over a live table, mostly small periods
    task automatic test_random_traffic;
        int          roll;
        logic [2:0]  op;
        logic [7:0]  slot;
        logic [31:0] period;
        logic [7:0]  hnd;
        logic [15:0] arg;
        begin
            for (int k = 0; k < RANDOM_ITEMS; k++) begin
                if (k % 10 == 0) begin
                    rx_mode    = t_rx_mode'($urandom_range(0, 3));
                    rx_pattern = 8'($urandom) | 8'h01;
                    gaps_on    = ($urandom_range(0, 3) != 0);
                end
                if (k == RANDOM_ITEMS / 2) begin
                    hold_req = HOLD_OFF_LEN / 2;
                    hold_offs++;
                end
                slot   = 8'($urandom);
                period = $urandom;
                hnd    = 8'($urandom);
                arg    = 16'($urandom);
                roll   = $urandom_range(0, 99);
                if (roll < 30)
                    op = mstt_pkg::OP_TICK;
                else if (roll < 42)
                    op = mstt_pkg::OP_START_PER;
                else if (roll < 55)
                    op = mstt_pkg::OP_START_ONE;
                else if (roll < 75)
                    op = mstt_pkg::OP_CLEAR;
                else if (roll < 94)
                    op = mstt_pkg::OP_SERVICE;
                else
                    op = 3'(OP_RESERVED_FIRST + $urandom_range(0, OP_RESERVED_SPAN - 1));
                if (op == mstt_pkg::OP_START_PER || op == mstt_pkg::OP_START_ONE) begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7)
                        period = $urandom_range(0, 5);
                    else if (roll < 9)
                        period = $urandom_range(6, 40);
                    if ($urandom_range(0, 4) == 0)
                        hnd = 8'h00;
                end
                if (op == mstt_pkg::OP_CLEAR)
                    slot = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NSLOT, 255))
                                                       : 8'($urandom_range(0, NSLOT - 1));
                send_command(op, slot, period, hnd, arg);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        i_m_tready     = 1'b0;
        burst_left     = 0;
        gaps_on        = 1'b0;
        rx_mode        = RX_ALWAYS;
        rx_pattern     = 8'hFF;
        rx_phase       = 0;
        hold_req       = 0;
        hold_left      = 0;
        mismatch_count = 0;
        commands_sent  = 0;
        results_seen   = 0;
        fired_seen     = 0;
        hold_offs      = 0;
        for (int i = 0; i < NSLOT; i++)
            shadow_table[i] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table;
        test_start_and_fire;
        test_clear_keeps_pending;
        test_backpressure;
        test_pending_saturation;
        test_random_traffic;
        wait_drained(SETTLE_CYCLES);

        $display("Sent %0d commands (ticks, starts, clears, services, ignored codes);",
                 commands_sent);
        $display("checked %0d results, %0d of them fired slots, across %0d receiver hold-offs.",
                 results_seen, fired_seen, hold_offs);
        if (mismatch_count == 0)
            $display("multi_slot_tick_timer_table_top_tb: clean");
        else
            $display("multi_slot_tick_timer_table_top_tb: errors");
        $finish;
    end

    // Give up if the run stalls
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("multi_slot_tick_timer_table_top_tb: errors");
        $finish;
    end

endmodule

// ===== multi_slot_tick_timer_table_top.f =====
hw/rtl/mstt_pkg.sv
hw/rtl/mstt_seq.sv
hw/rtl/mstt_dp.sv
hw/rtl/multi_slot_tick_timer_table_top.sv
bench/multi_slot_tick_timer_table_top_tb.sv
